[hw/rtl/lrs_pkg.sv]
`default_nettype none

package lrs_pkg;

   // Fixed field widths
   localparam int SAMPLE_W    = 32;
   localparam int ROW_W       = 16;
   localparam int COL_W       = 10;
   localparam int CFG_COLS_W  = 11;
   localparam int LAP_W       = 35;
   localparam int VALUE_W     = 36;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int MAX_COLS_DEFAULT = 1024;

   localparam logic [ROW_W-1:0]      GRID_ROWS_RESET     = 16'd64;
   localparam logic [CFG_COLS_W-1:0] GRID_COLS_RESET     = 11'd64;
   localparam logic                  RESIDUAL_MODE_RESET = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_ROWS     = 2'd0,
      CSR_GRID_COLS     = 2'd1,
      CSR_RESIDUAL_MODE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] u_sample;
      logic signed [SAMPLE_W-1:0] f_sample;
   } lrs_req_type;

   typedef struct packed {
      logic [ROW_W-1:0]          out_row;
      logic [COL_W-1:0]          out_col;
      logic signed [VALUE_W-1:0] out_value;
      logic                      run_last;
      logic                      grid_done;
   } lrs_rsp_type;

   // Line store write: new u, the u that moves to the upper line, new f
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] u;
      logic signed [SAMPLE_W-1:0] center;
      logic signed [SAMPLE_W-1:0] f;
   } line_wr_type;

   // Line store read, already corrected for a write to the same column
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] lower_c;
      logic signed [SAMPLE_W-1:0] lower_n;
      logic signed [SAMPLE_W-1:0] upper_c;
      logic signed [SAMPLE_W-1:0] f_c;
   } line_rd_type;

endpackage

`default_nettype wire

[hw/rtl/lrs_line_buf.sv]
`default_nettype none

module lrs_line_buf #(
   parameter int MAX_COLS = lrs_pkg::MAX_COLS_DEFAULT,
   parameter int ADDR_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   input  wire logic [ADDR_W-1:0]   rd_next_addr,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire lrs_pkg::line_wr_type wr_data,
   output lrs_pkg::line_rd_type     rd_data
);
   import lrs_pkg::*;

   logic [SAMPLE_W-1:0] lower_mem [MAX_COLS];
   logic [SAMPLE_W-1:0] upper_mem [MAX_COLS];
   logic [SAMPLE_W-1:0] f_mem     [MAX_COLS];

   logic [SAMPLE_W-1:0] lower_c_ff;
   logic [SAMPLE_W-1:0] lower_n_ff;
   logic [SAMPLE_W-1:0] upper_c_ff;
   logic [SAMPLE_W-1:0] f_c_ff;
   logic                hit_c_ff;
   logic                hit_n_ff;
   line_wr_type         fwd_ff;

   // Read returns old contents on a same-address write; catch that as a hit
   always_ff @(posedge clock) begin
      if (wr_en) begin
         lower_mem[wr_addr] <= wr_data.u;
         upper_mem[wr_addr] <= wr_data.center;
         f_mem[wr_addr]     <= wr_data.f;
      end
      if (rd_en) begin
         lower_c_ff <= lower_mem[rd_addr];
         lower_n_ff <= lower_mem[rd_next_addr];
         upper_c_ff <= upper_mem[rd_addr];
         f_c_ff     <= f_mem[rd_addr];
         hit_c_ff   <= wr_en && (wr_addr == rd_addr);
         hit_n_ff   <= wr_en && (wr_addr == rd_next_addr);
         fwd_ff     <= wr_data;
      end
   end

   always_comb begin
      rd_data.lower_c = hit_c_ff ? fwd_ff.u      : lower_c_ff;
      rd_data.lower_n = hit_n_ff ? fwd_ff.u      : lower_n_ff;
      rd_data.upper_c = hit_c_ff ? fwd_ff.center : upper_c_ff;
      rd_data.f_c     = hit_c_ff ? fwd_ff.f      : f_c_ff;
   end

   a_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> $past(rd_en))
      else $error("line write without a read one cycle earlier");

   a_fwd_lower: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (rd_addr == wr_addr) |=> (rd_data.lower_c == $past(wr_data.u)))
      else $error("same-column write not forwarded to lower line read");

   a_fwd_next: assert property (@(posedge clock) disable iff (reset)
      rd_en && wr_en && (rd_next_addr == wr_addr) |=>
         (rd_data.lower_n == $past(wr_data.u)))
      else $error("same-column write not forwarded to right neighbor read");

endmodule

`default_nettype wire

[hw/rtl/laplacian_residual_stencil.sv]
`default_nettype none

// Five-point Laplacian / residual stencil with Neumann edges. Feed u and f
// of a grid_rows x grid_cols grid in raster order, one request per point;
// each result carries its row and column. Mode 1 returns f - L, mode 0
// returns L, exact in 36 bits signed Q20.16. Results of an inner row come
// out when the point below arrives, results of the last row when the point
// to the right arrives; the final request of the grid returns up to three.
// Rate: one request per cycle while each request yields at most one result
// and rsp_ready is high. In the last row of a grid with two or more rows,
// every request after the first column yields two results and the final one
// yields three with two or more columns; the single result port then sets
// the pace. Requests pass through stage B, then the result slots. The rows
// above live in two u line memories and one f line memory, each MAX_COLS
// deep, read at the edge that takes the request and written at the edge
// after. No clearing pass after reset. The user must keep geometry and mode
// registers written only while no request is in flight; no check enforces it.
module laplacian_residual_stencil #(
   parameter int MAX_COLS = lrs_pkg::MAX_COLS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire lrs_pkg::lrs_req_type           req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lrs_pkg::lrs_rsp_type                rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lrs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lrs_pkg::*;

   localparam int ADDR_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int NC_W   = 17;
   localparam logic [NC_W-1:0] MaxColsN = NC_W'(MAX_COLS);

   localparam logic [1:0] SLOT_INNER = 2'd0;
   localparam logic [1:0] SLOT_EDGE  = 2'd1;
   localparam logic [1:0] SLOT_FINAL = 2'd2;

   // ---------------- configuration registers ----------------
   logic [ROW_W-1:0]      grid_rows_ff;
   logic [CFG_COLS_W-1:0] grid_cols_ff;
   logic                  residual_mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff     <= GRID_ROWS_RESET;
         grid_cols_ff     <= GRID_COLS_RESET;
         residual_mode_ff <= RESIDUAL_MODE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GRID_ROWS:     grid_rows_ff     <= csr_wdata[ROW_W-1:0];
            CSR_GRID_COLS:     grid_cols_ff     <= csr_wdata[CFG_COLS_W-1:0];
            CSR_RESIDUAL_MODE: residual_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective geometry: zero rows counts as one, columns clamp to 1..MAX_COLS
   logic [ROW_W-1:0] num_rows;
   logic [NC_W-1:0]  num_cols;

   always_comb begin
      num_rows = (grid_rows_ff == '0) ? ROW_W'(1) : grid_rows_ff;
      num_cols = NC_W'(grid_cols_ff);
      if (num_cols == '0) begin
         num_cols = NC_W'(1);
      end else if (num_cols > MaxColsN) begin
         num_cols = MaxColsN;
      end
   end

   // ---------------- raster position ----------------
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  cur_row;
   logic [ADDR_W-1:0] cur_col;
   logic [NC_W-1:0]   col_next_n;
   logic [ROW_W:0]    row_next_n;
   logic              restart;
   logic              at_last_col;
   logic              at_last_row;
   logic [ADDR_W-1:0] rd_next_addr;

   logic req_accept;
   logic b_adv;

   always_comb begin
      // restart at the origin when a geometry change left us outside the grid
      restart     = (row_ff >= num_rows) || (NC_W'(col_ff) >= num_cols);
      cur_row     = restart ? '0 : row_ff;
      cur_col     = restart ? '0 : col_ff;
      col_next_n  = NC_W'(cur_col) + NC_W'(1);
      row_next_n  = (ROW_W+1)'(cur_row) + (ROW_W+1)'(1);
      at_last_col = (col_next_n == num_cols);
      at_last_row = (row_next_n == (ROW_W+1)'(num_rows));
      rd_next_addr = (col_next_n < MaxColsN) ? ADDR_W'(col_next_n) : '0;

      row_in = row_ff;
      col_in = col_ff;
      if (req_accept) begin
         if (!at_last_col) begin
            row_in = cur_row;
            col_in = ADDR_W'(col_next_n);
         end else begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_next_n[ROW_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- stage B: line data arrives, stencil sums ----------------
   logic                       b_valid_ff, b_valid_in;
   logic                       b_first_ff;
   logic signed [SAMPLE_W-1:0] b_u_ff, b_f_ff;
   logic [ROW_W-1:0]           b_row_ff;
   logic [ADDR_W-1:0]          b_col_ff;
   logic                       b_inner_ff;  // row > 0: point above is due
   logic                       b_up_ff;     // row > 1
   logic                       b_left_ff;   // col > 0
   logic                       b_left2_ff;  // col > 1
   logic                       b_right_ff;  // not the last column
   logic                       b_lastrow_ff;
   logic                       b_final_ff;

   assign req_ready  = !b_valid_ff || b_adv;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      b_valid_in = b_valid_ff;
      if (req_accept) begin
         b_valid_in = 1'b1;
      end else if (b_adv) begin
         b_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_first_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
         b_first_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_u_ff       <= req_data.u_sample;
         b_f_ff       <= req_data.f_sample;
         b_row_ff     <= cur_row;
         b_col_ff     <= cur_col;
         b_inner_ff   <= (cur_row != '0);
         b_up_ff      <= (cur_row > ROW_W'(1));
         b_left_ff    <= (cur_col != '0);
         b_left2_ff   <= (cur_col > ADDR_W'(1));
         b_right_ff   <= !at_last_col;
         b_lastrow_ff <= at_last_row;
         b_final_ff   <= at_last_row && at_last_col;
      end
   end

   // line memories: read on request, shift column in the following cycle
   line_wr_type lb_wr;
   line_rd_type lb_rd;

   assign lb_wr.u      = b_u_ff;
   assign lb_wr.center = lb_rd.lower_c;
   assign lb_wr.f      = b_f_ff;

   lrs_line_buf #(
      .MAX_COLS (MAX_COLS),
      .ADDR_W   (ADDR_W)
   ) u_line_buf (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (req_accept),
      .rd_addr      (cur_col),
      .rd_next_addr (rd_next_addr),
      .wr_en        (b_first_ff),
      .wr_addr      (b_col_ff),
      .wr_data      (lb_wr),
      .rd_data      (lb_rd)
   );

   // History of the previous request in the same row
   logic signed [SAMPLE_W-1:0] hist_center_ff;  // u one row up, one column left
   logic signed [SAMPLE_W-1:0] hist_u1_ff;      // u one column left
   logic signed [SAMPLE_W-1:0] hist_u2_ff;      // u two columns left
   logic signed [SAMPLE_W-1:0] hist_f_ff;       // f one column left

   always_ff @(posedge clock) begin
      if (b_adv) begin
         hist_center_ff <= lb_rd.lower_c;
         hist_u2_ff     <= hist_u1_ff;
         hist_u1_ff     <= b_u_ff;
         hist_f_ff      <= b_f_ff;
      end
   end

   logic signed [LAP_W-1:0] u_x, ctr_x, up_x, right_x, hc_x, h1_x, h2_x;
   logic signed [LAP_W-1:0] inner_lap, edge_lap, final_lap;

   always_comb begin
      u_x     = LAP_W'(b_u_ff);
      ctr_x   = LAP_W'(lb_rd.lower_c);
      up_x    = LAP_W'(lb_rd.upper_c);
      right_x = LAP_W'(lb_rd.lower_n);
      hc_x    = LAP_W'(hist_center_ff);
      h1_x    = LAP_W'(hist_u1_ff);
      h2_x    = LAP_W'(hist_u2_ff);

      // point above: its lower neighbour is the new sample
      inner_lap = ctr_x - u_x;
      if (b_up_ff) begin
         inner_lap = inner_lap + (ctr_x - up_x);
      end
      if (b_left_ff) begin
         inner_lap = inner_lap + (ctr_x - hc_x);
      end
      if (b_right_ff) begin
         inner_lap = inner_lap + (ctr_x - right_x);
      end

      // last row, point to the left: its right neighbour is the new sample
      edge_lap = h1_x - u_x;
      if (b_inner_ff) begin
         edge_lap = edge_lap + (h1_x - hc_x);
      end
      if (b_left2_ff) begin
         edge_lap = edge_lap + (h1_x - h2_x);
      end

      // final point of the grid: only up and left can exist
      final_lap = '0;
      if (b_inner_ff) begin
         final_lap = final_lap + (u_x - ctr_x);
      end
      if (b_left_ff) begin
         final_lap = final_lap + (u_x - h1_x);
      end
   end

   // ---------------- result slots and output ----------------
   logic [2:0]                 slot_v_ff, slot_v_in;
   logic signed [LAP_W-1:0]    slot_lap_ff [3];
   logic signed [SAMPLE_W-1:0] slot_f_ff   [3];
   logic [ROW_W-1:0]           s_row_ff;
   logic [ADDR_W-1:0]          s_col_ff;
   logic [1:0]                 sel;
   logic                       sel_last;
   logic                       s_free;

   always_comb begin
      if (slot_v_ff[SLOT_INNER]) begin
         sel      = SLOT_INNER;
         sel_last = !slot_v_ff[SLOT_EDGE] && !slot_v_ff[SLOT_FINAL];
      end else if (slot_v_ff[SLOT_EDGE]) begin
         sel      = SLOT_EDGE;
         sel_last = !slot_v_ff[SLOT_FINAL];
      end else begin
         sel      = SLOT_FINAL;
         sel_last = 1'b1;
      end
   end

   assign rsp_valid = (slot_v_ff != '0);
   assign s_free    = !rsp_valid || (rsp_ready && sel_last);
   assign b_adv     = b_valid_ff && s_free;

   always_comb begin
      slot_v_in = slot_v_ff;
      if (rsp_valid && rsp_ready) begin
         slot_v_in[sel] = 1'b0;
      end
      if (b_adv) begin
         slot_v_in = {b_final_ff, b_lastrow_ff && b_left_ff, b_inner_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_v_ff <= '0;
      end else begin
         slot_v_ff <= slot_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (b_adv) begin
         slot_lap_ff[SLOT_INNER] <= inner_lap;
         slot_lap_ff[SLOT_EDGE]  <= edge_lap;
         slot_lap_ff[SLOT_FINAL] <= final_lap;
         slot_f_ff[SLOT_INNER]   <= lb_rd.f_c;
         slot_f_ff[SLOT_EDGE]    <= hist_f_ff;
         slot_f_ff[SLOT_FINAL]   <= b_f_ff;
         s_row_ff                <= b_row_ff;
         s_col_ff                <= b_col_ff;
      end
   end

   logic signed [VALUE_W-1:0] lap_v, f_v;

   always_comb begin
      lap_v = VALUE_W'(slot_lap_ff[sel]);
      f_v   = VALUE_W'(slot_f_ff[sel]);

      rsp_data.out_value = residual_mode_ff ? (f_v - lap_v) : lap_v;
      rsp_data.out_row   = (sel == SLOT_INNER) ? (s_row_ff - ROW_W'(1)) : s_row_ff;
      rsp_data.out_col   = (sel == SLOT_EDGE) ? COL_W'(s_col_ff - ADDR_W'(1))
                                              : COL_W'(s_col_ff);
      rsp_data.run_last  = sel_last;
      rsp_data.grid_done = (sel == SLOT_FINAL);
   end

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.grid_done |-> rsp_data.run_last)
      else $error("grid end result is not the last of its request");

   a_accept_frees_b: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && b_valid_ff |-> b_adv)
      else $error("request taken while stage B is held");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.run_last && !b_adv |=> !rsp_valid)
      else $error("result slots not empty after last result of a request");

endmodule

`default_nettype wire

[tb/stencil_check_pkg.sv]
package stencil_check_pkg;
   import lrs_pkg::*;

   class stencil_board;
      logic [ROW_W-1:0]           rows_reg;
      logic [CFG_COLS_W-1:0]      cols_reg;
      logic                       residual_reg;
      logic signed [SAMPLE_W-1:0] u_upper [MAX_COLS_DEFAULT];
      logic signed [SAMPLE_W-1:0] u_lower [MAX_COLS_DEFAULT];
      logic signed [SAMPLE_W-1:0] f_keep  [MAX_COLS_DEFAULT];
      int unsigned                row_pos;
      int unsigned                col_pos;
      longint                     prev_u;
      lrs_rsp_type                pending_points [$];
      int                         errors;
      int                         shown;

      function new();
         rows_reg     = GRID_ROWS_RESET;
         cols_reg     = GRID_COLS_RESET;
         residual_reg = RESIDUAL_MODE_RESET;
         row_pos      = 0;
         col_pos      = 0;
         prev_u       = 0;
         errors       = 0;
         shown        = 0;
      endfunction

      function void write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_GRID_ROWS:     rows_reg = data[ROW_W-1:0];
            CSR_GRID_COLS:     cols_reg = data[CFG_COLS_W-1:0];
            CSR_RESIDUAL_MODE: residual_reg = data[0];
            default: ;
         endcase
      endfunction

      function lrs_rsp_type make_point(input int unsigned r, input int unsigned c,
                                       input longint lap, input longint f_val, input bit done);
         lrs_rsp_type p;
         longint      v;
         v           = residual_reg ? f_val - lap : lap;
         p.out_row   = r[ROW_W-1:0];
         p.out_col   = c[COL_W-1:0];
         p.out_value = v[VALUE_W-1:0];
         p.run_last  = 1'b0;
         p.grid_done = done;
         return p;
      endfunction

      // Advance the grid by one point and queue the points it completes.
      function void note_request(input lrs_req_type req);
         int unsigned nr;
         int unsigned nc;
         int unsigned r;
         int unsigned c;
         longint      uin;
         longint      fin;
         longint      lap;
         longint      u0;
         lrs_rsp_type found [3];
         int          n;
         nr = (rows_reg == 0) ? 1 : rows_reg;
         nc = cols_reg;
         if (nc < 1) nc = 1;
         if (nc > MAX_COLS_DEFAULT) nc = MAX_COLS_DEFAULT;
         if (row_pos >= nr || col_pos >= nc) begin
            row_pos = 0;
            col_pos = 0;
         end
         r   = row_pos;
         c   = col_pos;
         uin = $signed(req.u_sample);
         fin = $signed(req.f_sample);
         n   = 0;

         // point above is complete once the one below shows up
         if (r > 0) begin
            u0  = u_lower[c];
            lap = u0 - uin;
            if (r > 1) lap += u0 - u_upper[c];
            if (c > 0) lap += u0 - u_upper[c-1];
            if (c + 1 < nc) lap += u0 - u_lower[c+1];
            found[n] = make_point(r - 1, c, lap, f_keep[c], 1'b0);
            n++;
         end

         u_upper[c] = u_lower[c];
         u_lower[c] = uin;
         f_keep[c]  = fin;

         if (r == nr - 1) begin
            // last row: left neighbor is complete once this one arrives
            if (c > 0) begin
               u0  = prev_u;
               lap = u0 - uin;
               if (r > 0) lap += u0 - u_upper[c-1];
               if (c > 1) lap += u0 - u_lower[c-2];
               found[n] = make_point(r, c - 1, lap, f_keep[c-1], 1'b0);
               n++;
            end
            if (c == nc - 1) begin
               lap = 0;
               if (r > 0) lap += uin - u_upper[c];
               if (c > 0) lap += uin - u_lower[c-1];
               found[n] = make_point(r, c, lap, fin, 1'b1);
               n++;
            end
         end
         if (n > 0) found[n-1].run_last = 1'b1;
         for (int i = 0; i < n; i++) pending_points.push_back(found[i]);

         prev_u = uin;
         if (c + 1 < nc) begin
            col_pos = c + 1;
         end else begin
            col_pos = 0;
            row_pos = (r + 1 < nr) ? r + 1 : 0;
         end
      endfunction

      function void check_response(input lrs_rsp_type got);
         lrs_rsp_type want;
         if (pending_points.size() == 0) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("unexpected result: row %0d col %0d value %0d last %0b done %0b",
                        got.out_row, got.out_col, got.out_value, got.run_last, got.grid_done);
            end
            return;
         end
         want = pending_points.pop_front();
         if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
             got.out_value !== want.out_value || got.run_last !== want.run_last ||
             got.grid_done !== want.grid_done) begin
            errors++;
            if (shown < 10) begin
               shown++;
               $display("mismatch: expected row %0d col %0d value %0d last %0b done %0b",
                        want.out_row, want.out_col, want.out_value, want.run_last,
                        want.grid_done);
               $display("          actual   row %0d col %0d value %0d last %0b done %0b",
                        got.out_row, got.out_col, got.out_value, got.run_last, got.grid_done);
            end
         end
      endfunction

      function int outstanding();
         return pending_points.size();
      endfunction
   endclass

endpackage

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lrs_pkg::*;
   import stencil_check_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int DRAIN_CYCLES    = 8;      // margin for the pipeline to empty
   localparam int HOLD_OFF_CYCLES = 300;    // long enough to back the block up
   localparam int WATCHDOG_LIMIT  = 4000;   // well above the longest legal quiet stretch
   localparam int RANDOM_ITEMS    = 230;
   localparam int BIG_COLS        = 2047;   // clamps to the full line depth
   localparam int BIG_ROW_ITEMS   = 48;     // part of the first row of the wide grid

   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 32'h7FFF_FFFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 32'h8000_0000;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   lrs_req_type             req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   lrs_rsp_type             rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   stencil_board board;
   int           req_idle_pct = 0;
   int           rsp_idle_pct = 0;
   int           rsp_hold     = 0;
   bit           hold_off_req = 1'b0;
   int           stall_cycles = 0;

   laplacian_residual_stencil u_top (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always #6 clock = ~clock;

   // Gap length for either side: mostly none, sometimes a short one, rarely a long one.
   function automatic int pick_gap(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(60, 20);
      return $urandom_range(3, 1);
   endfunction

   // Lean on the extremes and on all-ones / zero, otherwise a full random word.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(15))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request: optionally drop valid for a gap first, then hold
   // the payload until the block takes it and log it with the predictor.
   task automatic send_request(input logic [SAMPLE_W-1:0] u, input logic [SAMPLE_W-1:0] f);
      int          gap;
      lrs_req_type item;
      gap           = pick_gap(req_idle_pct);
      item.u_sample = u;
      item.f_sample = f;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      board.note_request(item);
      @(negedge clock);
   endtask

   // Write one register; keep valid up when another write follows right away.
   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data,
                                 input bit drop_valid);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!(csr_valid && csr_ready)) @(posedge clock);
      board.write_register(idx, data);
      @(negedge clock);
      if (drop_valid) csr_valid <= 1'b0;
   endtask

   task automatic configure(input int rows, input int cols, input bit mode);
      write_register(CSR_GRID_ROWS, rows[CSR_DATA_W-1:0], 1'b0);
      write_register(CSR_GRID_COLS, cols[CSR_DATA_W-1:0], 1'b0);
      write_register(CSR_RESIDUAL_MODE, {{(CSR_DATA_W-1){1'b0}}, mode}, 1'b1);
   endtask

   // Drop the request valid, wait for every predicted point, then let any
   // request that produces no point clear the pipeline before the next write.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Result side: random stalls, plus one long hold-off whenever asked.
   // The hold-off is counted here so the sender keeps pushing meanwhile.
   always @(negedge clock) begin
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         rsp_hold     = HOLD_OFF_CYCLES;
      end else if (rsp_hold == 0) begin
         rsp_hold = pick_gap(rsp_idle_pct);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // Count cycles without any handshake on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("** laplacian_residual_stencil: FAILED **");
      $finish;
   end

   initial begin
      int rows_sel;
      int cols_sel;
      int nr;
      int nc;
      int count;
      int sent;
      board = new();
      sent  = 0;

      // Hold reset for the required cycles, release it away from the edge.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part runs without idling on either side.
      req_idle_pct = 0;
      rsp_idle_pct = 0;

      // Single-point grid: no neighbors at all, so the result is f itself.
      configure(1, 1, 1'b1);
      send_request(SAMPLE_MAX, SAMPLE_MIN);
      send_request(SAMPLE_MIN, SAMPLE_MAX);
      settle();

      // Zero rows and zero columns both fold to a single point; plain Laplacian.
      configure(0, 0, 1'b0);
      send_request('1, 32'h1234_5678);
      settle();

      // 3x3 checkerboard of extremes: corners, edges and the center all at
      // the largest differences the sample width allows.
      configure(3, 3, 1'b1);
      for (int i = 0; i < 9; i++)
         send_request((i % 2) ? SAMPLE_MIN : SAMPLE_MAX, (i % 3 == 0) ? SAMPLE_MIN : SAMPLE_MAX);
      settle();

      // Flip the mode halfway through a grid: earlier points stay Laplacian,
      // later ones become residuals.
      configure(2, 3, 1'b0);
      repeat (4) send_request(pick_sample(), pick_sample());
      settle();
      write_register(CSR_RESIDUAL_MODE, CSR_DATA_W'(1), 1'b1);
      repeat (2) send_request(pick_sample(), pick_sample());
      settle();

      // Tallest grid, one column wide; then shrink the rows under the current
      // position so the block restarts at the origin and finishes a 2x1 grid.
      configure(65535, 1, 1'b0);
      repeat (4) send_request(pick_sample(), pick_sample());
      settle();
      write_register(CSR_GRID_ROWS, CSR_DATA_W'(2), 1'b1);
      repeat (2) send_request(pick_sample(), pick_sample());
      settle();

      // Oversized column count clamps to the full line depth; in a single row
      // every request after the first yields one result. Run part of that
      // row, so the next geometry write leaves the position outside the grid
      // and restarts at the origin. Choke the result side right away so the
      // block backs up and stalls requests.
      req_idle_pct = 10;
      rsp_idle_pct = 10;
      hold_off_req = 1'b1;
      configure(1, BIG_COLS, 1'($urandom_range(1)));
      repeat (BIG_ROW_ITEMS) send_request(pick_sample(), pick_sample());
      settle();

      // Random phases: whole grids only, so every line entry a result uses was written
      // by the same grid. Mostly small shapes, now and then a wider one.
      while (sent < RANDOM_ITEMS) begin
         rows_sel = $urandom_range(6, 0);
         case ($urandom_range(7))
            0: cols_sel = 0;
            1: begin
               cols_sel = $urandom_range(40, 16);
               if (rows_sel > 3) rows_sel = 3;
            end
            default: cols_sel = $urandom_range(10, 1);
         endcase
         nr           = (rows_sel == 0) ? 1 : rows_sel;
         nc           = (cols_sel == 0) ? 1 : cols_sel;
         count        = nr * nc * $urandom_range(2, 1);
         req_idle_pct = 20 * $urandom_range(3);
         rsp_idle_pct = 20 * $urandom_range(3);
         configure(rows_sel, cols_sel, 1'($urandom_range(1)));
         if ($urandom_range(5) == 0) hold_off_req = 1'b1;
         repeat (count) send_request(pick_sample(), pick_sample());
         settle();
         sent += count;
      end

      if (board.errors == 0 && board.outstanding() == 0)
         $display("** laplacian_residual_stencil: PASSED **");
      else
         $display("** laplacian_residual_stencil: FAILED **");
      $finish;
   end

endmodule
